[rtl/mcp_pkg.sv]
// Shared types and constants for the MIDI channel message parser.
// No dependencies; every other file imports this package.
package mcp_pkg;

    // Result kinds as seen on event_kind.
    typedef enum logic [2:0] {
        EV_NOTE_ON    = 3'd0,
        EV_NOTE_OFF   = 3'd1,
        EV_MOD_WHEEL  = 3'd2,
        EV_PITCH_BEND = 3'd3,
        EV_AFTERTOUCH = 3'd4,
        EV_CLOCK      = 3'd5,
        EV_START      = 3'd6,
        EV_SYSEX_PARAM = 3'd7
    } event_kind_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LISTEN_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_DEVICE_ID      = 2'd1;
    localparam logic [1:0] CFG_LOWEST_NOTE    = 2'd2;
    localparam logic [1:0] CFG_HIGHEST_NOTE   = 2'd3;

    // MIDI byte codes.
    localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
    localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
    localparam logic [7:0] MIDI_REALTIME    = 8'hF8;
    localparam logic [7:0] MIDI_SYNC_CLOCK  = 8'hF8;
    localparam logic [7:0] MIDI_START       = 8'hFA;
    localparam logic [7:0] MIDI_RESUME      = 8'hFB;

    // Status nibbles of the channel voice messages.
    localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
    localparam logic [3:0] STAT_CTRL       = 4'hB;
    localparam logic [3:0] STAT_PROGRAM    = 4'hC;
    localparam logic [3:0] STAT_PRESSURE   = 4'hD;
    localparam logic [3:0] STAT_PITCH_BEND = 4'hE;

    // Opcode of an input beat.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Depth of the event queue between parser and output stage.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration seen by the parser.
    typedef struct packed {
        logic [3:0] listen_channel;
        logic [3:0] device_id;
        logic [6:0] lowest_note;
        logic [6:0] highest_note;
    } cfg_t;

    // Compact event record: field_a and field_b carry note/velocity or
    // module/control; value carries the 14-bit value or the clock interval.
    typedef struct packed {
        event_kind_t kind;
        logic [6:0]  field_a;
        logic [6:0]  field_b;
        logic [15:0] value;
    } ev_t;

endpackage

[rtl/mcp_front.sv]
// Parser front end: running-status state machine, held bytes and tick counter.
// Depends on mcp_pkg; emits compact event records toward the event queue.
module mcp_front
    import mcp_pkg::*;
#(
    parameter logic [6:0] MOD_WHEEL_CC   = 7'd1,
    parameter logic [6:0] SYSEX_MAKER_ID = 7'd125
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    output logic       push,
    output ev_t        push_ev
);

    typedef enum logic [17:0] {
        ST_IDLE     = 18'd1 << 0,
        ST_ON_KEY   = 18'd1 << 1,
        ST_ON_VEL   = 18'd1 << 2,
        ST_OFF_KEY  = 18'd1 << 3,
        ST_OFF_VEL  = 18'd1 << 4,
        ST_CC_NUM   = 18'd1 << 5,
        ST_CC_VAL   = 18'd1 << 6,
        ST_PB_LO    = 18'd1 << 7,
        ST_PB_HI    = 18'd1 << 8,
        ST_AT       = 18'd1 << 9,
        ST_PC       = 18'd1 << 10,
        ST_SX_MAKER = 18'd1 << 11,
        ST_SX_ADDR  = 18'd1 << 12,
        ST_SX_MOD   = 18'd1 << 13,
        ST_SX_CTL   = 18'd1 << 14,
        ST_SX_HI    = 18'd1 << 15,
        ST_SX_LO    = 18'd1 << 16,
        ST_SX_END   = 18'd1 << 17
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  note_reg, note_next;
    logic [6:0]  cc_reg, cc_next;
    logic [6:0]  bend_lo_reg, bend_lo_next;
    logic [6:0]  sx_mod_reg, sx_mod_next;
    logic [6:0]  sx_ctl_reg, sx_ctl_next;
    logic [6:0]  sx_hi_reg, sx_hi_next;
    logic [6:0]  sx_lo_reg, sx_lo_next;
    logic [15:0] tick_reg, tick_next;
    logic        emit;
    ev_t         ev;
    logic [6:0]  data;
    logic        note_ok;

    // Decode a byte seen while idle: SysEx start or a status on our channel.
    function automatic state_t idle_next(logic [7:0] b, logic [3:0] ch);
        state_t s;
        s = ST_IDLE;
        if (b == MIDI_SYSEX_START)
        begin
            s = ST_SX_MAKER;
        end
        else if (b[3:0] == ch)
        begin
            case (b[7:4])
                STAT_NOTE_ON:    s = ST_ON_KEY;
                STAT_NOTE_OFF:   s = ST_OFF_KEY;
                STAT_CTRL:       s = ST_CC_NUM;
                STAT_PITCH_BEND: s = ST_PB_LO;
                STAT_PRESSURE:   s = ST_AT;
                STAT_PROGRAM:    s = ST_PC;
                default:         s = ST_IDLE;
            endcase
        end
        return s;
    endfunction

    assign data    = rx_byte[6:0];
    assign note_ok = (note_reg >= cfg.lowest_note) && (note_reg <= cfg.highest_note);

    // Next-state and event decode for one beat.
    always_comb
    begin
        state_next   = state_reg;
        note_next    = note_reg;
        cc_next      = cc_reg;
        bend_lo_next = bend_lo_reg;
        sx_mod_next  = sx_mod_reg;
        sx_ctl_next  = sx_ctl_reg;
        sx_hi_next   = sx_hi_reg;
        sx_lo_next   = sx_lo_reg;
        tick_next    = tick_reg;
        emit         = 1'b0;
        ev           = '0;

        if (opcode == OP_TICK)
        begin
            // Saturating tick count.
            if (tick_reg != 16'hFFFF)
            begin
                tick_next = tick_reg + 16'd1;
            end
        end
        else if (rx_byte >= MIDI_REALTIME)
        begin
            // Real-time bytes leave the parse state alone.
            if (rx_byte == MIDI_SYNC_CLOCK)
            begin
                emit      = 1'b1;
                ev.kind   = EV_CLOCK;
                ev.value  = tick_reg;
                tick_next = '0;
            end
            else if (rx_byte == MIDI_START || rx_byte == MIDI_RESUME)
            begin
                emit    = 1'b1;
                ev.kind = EV_START;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    state_next = idle_next(rx_byte, cfg.listen_channel);
                end
                ST_SX_MAKER:
                begin
                    if (rx_byte == {1'b0, SYSEX_MAKER_ID})
                        state_next = ST_SX_ADDR;
                    else
                        state_next = idle_next(rx_byte, cfg.listen_channel);
                end
                ST_SX_ADDR:
                begin
                    if (rx_byte == {cfg.device_id, cfg.listen_channel})
                        state_next = ST_SX_MOD;
                    else
                        state_next = idle_next(rx_byte, cfg.listen_channel);
                end
                ST_SX_END:
                begin
                    state_next = ST_IDLE;
                    if (rx_byte == MIDI_SYSEX_END)
                    begin
                        emit       = 1'b1;
                        ev.kind    = EV_SYSEX_PARAM;
                        ev.field_a = sx_mod_reg;
                        ev.field_b = sx_ctl_reg;
                        ev.value   = {2'b00, sx_hi_reg, sx_lo_reg};
                    end
                end
                default:
                begin
                    if (rx_byte[7])
                    begin
                        // A status byte ends the message and starts a new one.
                        state_next = idle_next(rx_byte, cfg.listen_channel);
                    end
                    else
                    begin
                        case (state_reg)
                            ST_ON_KEY:
                            begin
                                note_next  = data;
                                state_next = ST_ON_VEL;
                            end
                            ST_ON_VEL:
                            begin
                                state_next = ST_ON_KEY;
                                if (note_ok)
                                begin
                                    emit       = 1'b1;
                                    ev.field_a = note_reg;
                                    if (data != 7'd0)
                                    begin
                                        ev.kind    = EV_NOTE_ON;
                                        ev.field_b = data;
                                    end
                                    else
                                    begin
                                        ev.kind = EV_NOTE_OFF;
                                    end
                                end
                            end
                            ST_OFF_KEY:
                            begin
                                note_next  = data;
                                state_next = ST_OFF_VEL;
                            end
                            ST_OFF_VEL:
                            begin
                                state_next = ST_OFF_KEY;
                                if (note_ok)
                                begin
                                    emit       = 1'b1;
                                    ev.kind    = EV_NOTE_OFF;
                                    ev.field_a = note_reg;
                                end
                            end
                            ST_CC_NUM:
                            begin
                                cc_next    = data;
                                state_next = ST_CC_VAL;
                            end
                            ST_CC_VAL:
                            begin
                                state_next = ST_CC_NUM;
                                if (cc_reg == MOD_WHEEL_CC)
                                begin
                                    emit     = 1'b1;
                                    ev.kind  = EV_MOD_WHEEL;
                                    ev.value = {9'd0, data};
                                end
                            end
                            ST_PB_LO:
                            begin
                                bend_lo_next = data;
                                state_next   = ST_PB_HI;
                            end
                            ST_PB_HI:
                            begin
                                state_next = ST_PB_LO;
                                emit       = 1'b1;
                                ev.kind    = EV_PITCH_BEND;
                                ev.value   = {2'b00, data, bend_lo_reg};
                            end
                            ST_AT:
                            begin
                                emit     = 1'b1;
                                ev.kind  = EV_AFTERTOUCH;
                                ev.value = {9'd0, data};
                            end
                            ST_PC:
                            begin
                                state_next = ST_PC;
                            end
                            ST_SX_MOD:
                            begin
                                sx_mod_next = data;
                                state_next  = ST_SX_CTL;
                            end
                            ST_SX_CTL:
                            begin
                                sx_ctl_next = data;
                                state_next  = ST_SX_HI;
                            end
                            ST_SX_HI:
                            begin
                                sx_hi_next = data;
                                state_next = ST_SX_LO;
                            end
                            ST_SX_LO:
                            begin
                                sx_lo_next = data;
                                state_next = ST_SX_END;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign push    = accept && emit;
    assign push_ev = ev;

    // Parser state advances on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            note_reg    <= '0;
            cc_reg      <= '0;
            bend_lo_reg <= '0;
            sx_mod_reg  <= '0;
            sx_ctl_reg  <= '0;
            sx_hi_reg   <= '0;
            sx_lo_reg   <= '0;
            tick_reg    <= '0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            note_reg    <= note_next;
            cc_reg      <= cc_next;
            bend_lo_reg <= bend_lo_next;
            sx_mod_reg  <= sx_mod_next;
            sx_ctl_reg  <= sx_ctl_next;
            sx_hi_reg   <= sx_hi_next;
            sx_lo_reg   <= sx_lo_next;
            tick_reg    <= tick_next;
        end
    end

endmodule

[rtl/mcp_queue.sv]
// Short event queue between the parser front end and the output stage.
// Depends on mcp_pkg for the event record and the queue depth.
module mcp_queue
    import mcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ev_t  push_ev,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output ev_t  head_ev
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    ev_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != FULL);
    assign not_empty = (count_reg != '0);
    assign head_ev   = slot_reg[rptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Slot storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_ev;
        end
    end

endmodule

[rtl/mcp_back.sv]
// Output stage: spreads a compact event record over the result fields.
// Depends on mcp_pkg; holds the output register of the result channel.
module mcp_back
    import mcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  ev_t         q_ev,
    output logic        q_pop,
    output logic        event_valid,
    input  logic        event_ready,
    output logic [2:0]  event_kind,
    output logic [6:0]  note_number,
    output logic [6:0]  note_velocity,
    output logic [13:0] event_value,
    output logic [6:0]  param_module,
    output logic [6:0]  param_control,
    output logic [15:0] clock_interval
);

    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [6:0]  note_reg, vel_reg, mod_reg, ctl_reg;
    logic [13:0] value_reg;
    logic [15:0] interval_reg;
    logic [6:0]  note_next, vel_next, mod_next, ctl_next;
    logic [13:0] value_next;
    logic [15:0] interval_next;

    // Take a new beat when the output register is empty or being drained.
    assign q_pop = q_valid && (!valid_reg || event_ready);

    // Unused fields of each kind read as zero.
    always_comb
    begin
        note_next     = '0;
        vel_next      = '0;
        mod_next      = '0;
        ctl_next      = '0;
        value_next    = '0;
        interval_next = '0;
        case (q_ev.kind)
            EV_NOTE_ON:
            begin
                note_next = q_ev.field_a;
                vel_next  = q_ev.field_b;
            end
            EV_NOTE_OFF:
            begin
                note_next = q_ev.field_a;
            end
            EV_MOD_WHEEL, EV_PITCH_BEND, EV_AFTERTOUCH:
            begin
                value_next = q_ev.value[13:0];
            end
            EV_CLOCK:
            begin
                interval_next = q_ev.value;
            end
            EV_SYSEX_PARAM:
            begin
                mod_next   = q_ev.field_a;
                ctl_next   = q_ev.field_b;
                value_next = q_ev.value[13:0];
            end
            default:
            begin
                value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (event_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg     <= q_ev.kind;
            note_reg     <= note_next;
            vel_reg      <= vel_next;
            mod_reg      <= mod_next;
            ctl_reg      <= ctl_next;
            value_reg    <= value_next;
            interval_reg <= interval_next;
        end
    end

    assign event_valid    = valid_reg;
    assign event_kind     = kind_reg;
    assign note_number    = note_reg;
    assign note_velocity  = vel_reg;
    assign event_value    = value_reg;
    assign param_module   = mod_reg;
    assign param_control  = ctl_reg;
    assign clock_interval = interval_reg;

endmodule

[rtl/midi_channel_message_parser.sv]
// Top level of the MIDI channel message parser: configuration registers,
// parser front end, event queue and output stage (mcp_pkg, mcp_front, mcp_queue, mcp_back).
//
// The block takes one beat per clock: each beat is a received MIDI byte or a
// sync timer tick, and the parser handles it in the cycle in which it is
// accepted. An event that a beat raises enters a two-entry queue, from which
// the output stage moves it into its output register. item_ready drops only while
// that queue is full, which happens when the consumer holds event_ready low; so the
// sustained rate is one beat per cycle while event_ready stays high. The user must write
// configuration through cfg_wr_en/cfg_index/cfg_data only while idle; it is not enforced.
module midi_channel_message_parser
    import mcp_pkg::*;
#(
    parameter logic [6:0] MOD_WHEEL_CC   = 7'd1,
    parameter logic [6:0] SYSEX_MAKER_ID = 7'd125
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        event_valid,
    input  logic        event_ready,
    output logic [2:0]  event_kind,
    output logic [6:0]  note_number,
    output logic [6:0]  note_velocity,
    output logic [13:0] event_value,
    output logic [6:0]  param_module,
    output logic [6:0]  param_control,
    output logic [15:0] clock_interval
);

    cfg_t cfg_reg;
    logic accept;
    logic push, q_not_full, q_not_empty, q_pop;
    ev_t  push_ev, head_ev;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.listen_channel <= '0;
            cfg_reg.device_id      <= '0;
            cfg_reg.lowest_note    <= '0;
            cfg_reg.highest_note   <= 7'h7F;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LISTEN_CHANNEL: cfg_reg.listen_channel <= cfg_data[3:0];
                CFG_DEVICE_ID:      cfg_reg.device_id      <= cfg_data[3:0];
                CFG_LOWEST_NOTE:    cfg_reg.lowest_note    <= cfg_data;
                CFG_HIGHEST_NOTE:   cfg_reg.highest_note   <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // A beat is taken whenever the queue can absorb a possible event.
    assign item_ready = q_not_full;
    assign accept     = item_valid && item_ready;

    mcp_front #(
        .MOD_WHEEL_CC   (MOD_WHEEL_CC),
        .SYSEX_MAKER_ID (SYSEX_MAKER_ID)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .opcode  (opcode),
        .rx_byte (rx_byte),
        .push    (push),
        .push_ev (push_ev)
    );

    mcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ev   (push_ev),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_ev   (head_ev)
    );

    mcp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_not_empty),
        .q_ev           (head_ev),
        .q_pop          (q_pop),
        .event_valid    (event_valid),
        .event_ready    (event_ready),
        .event_kind     (event_kind),
        .note_number    (note_number),
        .note_velocity  (note_velocity),
        .event_value    (event_value),
        .param_module   (param_module),
        .param_control  (param_control),
        .clock_interval (clock_interval)
    );

endmodule

[tb/midi_channel_message_parser_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the MIDI channel message parser: watches the beat, event and
// register ports, predicts each event from the accepted bytes and ticks, and
// compares in order. Depends on mcp_pkg for event kinds and byte codes.
module midi_channel_message_parser_checker
    import mcp_pkg::*;
#(
    parameter logic [6:0] MOD_WHEEL_CC   = 7'd1,
    parameter logic [6:0] SYSEX_MAKER_ID = 7'd125
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic        event_valid,
    input  logic        event_ready,
    input  logic [2:0]  event_kind,
    input  logic [6:0]  note_number,
    input  logic [6:0]  note_velocity,
    input  logic [13:0] event_value,
    input  logic [6:0]  param_module,
    input  logic [6:0]  param_control,
    input  logic [15:0] clock_interval,
    output int          mismatch_count,
    output int          pending_count,
    output int          events_checked
);

    // Parser position within the current message.
    typedef enum logic [4:0] {
        PS_IDLE, PS_ON_KEY, PS_ON_VEL, PS_OFF_KEY, PS_OFF_VEL, PS_CC_NUM, PS_CC_VAL,
        PS_PB_LO, PS_PB_HI, PS_AT, PS_PC, PS_SX_MAKER, PS_SX_ADDR, PS_SX_MOD,
        PS_SX_CTL, PS_SX_HI, PS_SX_LO, PS_SX_END
    } parse_state_t;

    // One event as it appears on the output port.
    typedef struct packed {
        event_kind_t kind;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [13:0] value;
        logic [6:0]  mod_num;
        logic [6:0]  ctl_num;
        logic [15:0] interval;
    } midi_event_t;

    // Register copies, written from the configuration port.
    logic [3:0] cfg_channel;
    logic [3:0] cfg_device;
    logic [6:0] cfg_low;
    logic [6:0] cfg_high;

    // Predicted parser state.
    parse_state_t ps;
    logic [6:0]   note_hold;
    logic [6:0]   cc_hold;
    logic [6:0]   bend_low_hold;
    logic [6:0]   sx_mod;
    logic [6:0]   sx_ctl;
    logic [6:0]   sx_high;
    logic [6:0]   sx_low;
    logic [15:0]  tick_total;

    midi_event_t  pending_events[$];
    midi_event_t  want;
    midi_event_t  got;

    // Decode a byte seen while idle; only 0xF0 or a voice status on our
    // channel leaves idle.
    function automatic parse_state_t status_next(input logic [7:0] b);
        if (b == MIDI_SYSEX_START)
            return PS_SX_MAKER;
        if (b[3:0] != cfg_channel)
            return PS_IDLE;
        case (b[7:4])
            STAT_NOTE_ON:    return PS_ON_KEY;
            STAT_NOTE_OFF:   return PS_OFF_KEY;
            STAT_CTRL:       return PS_CC_NUM;
            STAT_PITCH_BEND: return PS_PB_LO;
            STAT_PRESSURE:   return PS_AT;
            STAT_PROGRAM:    return PS_PC;
            default:         return PS_IDLE;
        endcase
    endfunction

    function automatic bit note_in_range(input logic [6:0] n);
        return n >= cfg_low && n <= cfg_high;
    endfunction

    // Advance the predicted parser by one beat; returns 1 when the beat
    // raises an event, which is then placed in ev.
    function automatic bit predict_beat(input logic op, input logic [7:0] b,
                                        output midi_event_t ev);
        logic [6:0] d;
        ev = '0;
        d  = b[6:0];

        // Timer ticks only count, saturating at the top.
        if (op == OP_TICK) begin
            if (tick_total != 16'hFFFF)
                tick_total = tick_total + 16'd1;
            return 1'b0;
        end

        // Real-time bytes never touch the message state.
        if (b >= MIDI_REALTIME) begin
            if (b == MIDI_SYNC_CLOCK) begin
                ev.kind     = EV_CLOCK;
                ev.interval = tick_total;
                tick_total  = '0;
                return 1'b1;
            end
            if (b == MIDI_START || b == MIDI_RESUME) begin
                ev.kind = EV_START;
                return 1'b1;
            end
            return 1'b0;
        end

        // States that look at any byte, data or status.
        case (ps)
            PS_IDLE: begin
                ps = status_next(b);
                return 1'b0;
            end
            PS_SX_MAKER: begin
                ps = (b == {1'b0, SYSEX_MAKER_ID}) ? PS_SX_ADDR : status_next(b);
                return 1'b0;
            end
            PS_SX_ADDR: begin
                ps = (b == {cfg_device, cfg_channel}) ? PS_SX_MOD : status_next(b);
                return 1'b0;
            end
            PS_SX_END: begin
                ps = PS_IDLE;
                if (b != MIDI_SYSEX_END)
                    return 1'b0;
                ev.kind    = EV_SYSEX_PARAM;
                ev.value   = {sx_high, sx_low};
                ev.mod_num = sx_mod;
                ev.ctl_num = sx_ctl;
                return 1'b1;
            end
            default: ;
        endcase

        // A status byte inside a message ends it and starts over from idle.
        if (b[7]) begin
            ps = status_next(b);
            return 1'b0;
        end

        case (ps)
            PS_ON_KEY: begin
                note_hold = d;
                ps        = PS_ON_VEL;
            end
            PS_ON_VEL: begin
                ps = PS_ON_KEY;
                if (note_in_range(note_hold)) begin
                    ev.note = note_hold;
                    if (d != 7'd0) begin
                        ev.kind     = EV_NOTE_ON;
                        ev.velocity = d;
                    end else begin
                        ev.kind = EV_NOTE_OFF;
                    end
                    return 1'b1;
                end
            end
            PS_OFF_KEY: begin
                note_hold = d;
                ps        = PS_OFF_VEL;
            end
            PS_OFF_VEL: begin
                ps = PS_OFF_KEY;
                if (note_in_range(note_hold)) begin
                    ev.kind = EV_NOTE_OFF;
                    ev.note = note_hold;
                    return 1'b1;
                end
            end
            PS_CC_NUM: begin
                cc_hold = d;
                ps      = PS_CC_VAL;
            end
            PS_CC_VAL: begin
                ps = PS_CC_NUM;
                if (cc_hold == MOD_WHEEL_CC) begin
                    ev.kind  = EV_MOD_WHEEL;
                    ev.value = {7'd0, d};
                    return 1'b1;
                end
            end
            PS_PB_LO: begin
                bend_low_hold = d;
                ps            = PS_PB_HI;
            end
            PS_PB_HI: begin
                ps       = PS_PB_LO;
                ev.kind  = EV_PITCH_BEND;
                ev.value = {d, bend_low_hold};
                return 1'b1;
            end
            PS_AT: begin
                ev.kind  = EV_AFTERTOUCH;
                ev.value = {7'd0, d};
                return 1'b1;
            end
            PS_SX_MOD: begin
                sx_mod = d;
                ps     = PS_SX_CTL;
            end
            PS_SX_CTL: begin
                sx_ctl = d;
                ps     = PS_SX_HI;
            end
            PS_SX_HI: begin
                sx_high = d;
                ps      = PS_SX_LO;
            end
            PS_SX_LO: begin
                sx_low = d;
                ps     = PS_SX_END;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Track register writes, check delivered events, predict from accepted beats.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_channel    = '0;
            cfg_device     = '0;
            cfg_low        = 7'd0;
            cfg_high       = 7'd127;
            ps             = PS_IDLE;
            note_hold      = '0;
            cc_hold        = '0;
            bend_low_hold  = '0;
            sx_mod         = '0;
            sx_ctl         = '0;
            sx_high        = '0;
            sx_low         = '0;
            tick_total     = '0;
            pending_events.delete();
            mismatch_count = 0;
            pending_count  = 0;
            events_checked = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LISTEN_CHANNEL: cfg_channel = cfg_data[3:0];
                    CFG_DEVICE_ID:      cfg_device  = cfg_data[3:0];
                    CFG_LOWEST_NOTE:    cfg_low     = cfg_data;
                    CFG_HIGHEST_NOTE:   cfg_high    = cfg_data;
                    default: ;
                endcase
            end

            if (event_valid && event_ready) begin
                got.kind     = event_kind_t'(event_kind);
                got.note     = note_number;
                got.velocity = note_velocity;
                got.value    = event_value;
                got.mod_num  = param_module;
                got.ctl_num  = param_control;
                got.interval = clock_interval;
                if (pending_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR %0t: unexpected event kind=%0d note=%0d value=%0d",
                                 $realtime, got.kind, got.note, got.value);
                end else begin
                    want = pending_events.pop_front();
                    events_checked++;
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("ERROR %0t: event mismatch", $realtime);
                            $display({"  expected kind=%0d note=%0d vel=%0d value=%0d",
                                      " mod=%0d ctl=%0d ivl=%0d"},
                                     want.kind, want.note, want.velocity, want.value,
                                     want.mod_num, want.ctl_num, want.interval);
                            $display({"  actual   kind=%0d note=%0d vel=%0d value=%0d",
                                      " mod=%0d ctl=%0d ivl=%0d"},
                                     got.kind, got.note, got.velocity, got.value,
                                     got.mod_num, got.ctl_num, got.interval);
                        end
                    end
                end
            end

            if (item_valid && item_ready) begin
                if (predict_beat(opcode, rx_byte, want))
                    pending_events.push_back(want);
            end
            pending_count = pending_events.size();
        end
    end

endmodule

[tb/midi_channel_message_parser_tb.sv]
`timescale 1ns / 100ps
// Top of the MIDI channel message parser testbench: clock, reset, register
// writes, byte and tick stimulus, event consumer and verdict. Depends on
// mcp_pkg, the parser RTL and midi_channel_message_parser_checker.
module midi_channel_message_parser_tb;
    import mcp_pkg::*;

    localparam logic [6:0] MOD_WHEEL_CC   = 7'd1;
    localparam logic [6:0] SYSEX_MAKER_ID = 7'd125;

    // Byte codes the package does not name.
    localparam logic [7:0] MIDI_SONG_SELECT = 8'hF3;
    localparam logic [7:0] MIDI_RT_LAST     = 8'hFF;

    localparam int PHASE_BEATS  = 310;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        item_valid;
    logic        item_ready;
    logic        opcode;
    logic [7:0]  rx_byte;
    logic        event_valid;
    logic        event_ready;
    logic [2:0]  event_kind;
    logic [6:0]  note_number;
    logic [6:0]  note_velocity;
    logic [13:0] event_value;
    logic [6:0]  param_module;
    logic [6:0]  param_control;
    logic [15:0] clock_interval;

    int mismatch_count;
    int pending_count;
    int events_checked;

    // Testbench view of the registers, for steering the stimulus.
    logic [3:0] chan_now;
    logic [3:0] dev_now;
    logic [6:0] lo_now;
    logic [6:0] hi_now;

    beat_t beat_q[$];
    bit    idling_on    = 1'b1;
    int    holds_asked  = 0;
    int    holds_done   = 0;
    int    hold_left    = 0;
    int    stall_left   = 0;
    int    quiet_cycles = 0;
    int    cut_left     = 0;
    int    beats_sent   = 0;
    int    ticks_sent   = 0;
    int    settings_used = 0;

    midi_channel_message_parser #(
        .MOD_WHEEL_CC   (MOD_WHEEL_CC),
        .SYSEX_MAKER_ID (SYSEX_MAKER_ID)
    ) u_dut (.*);

    midi_channel_message_parser_checker #(
        .MOD_WHEEL_CC   (MOD_WHEEL_CC),
        .SYSEX_MAKER_ID (SYSEX_MAKER_ID)
    ) u_checker (.*);

    // 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Event consumer: random stall bursts, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            event_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            event_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            holds_done  <= holds_done + 1;
        end else if (stall_left != 0) begin
            event_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            event_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 10);
        end else begin
            event_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (event_valid && event_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one beat and hold it until accepted; may insert an idle burst first.
    task automatic send_beat(input logic op, input logic [7:0] b);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        rx_byte    <= b;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        beats_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    task automatic flush_beats();
        beat_t bt;
        while (beat_q.size() != 0) begin
            bt = beat_q.pop_front();
            send_beat(bt.op, bt.b);
        end
    endtask

    // Stop offering and wait until every predicted event has come out.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles.
    task automatic set_config(input logic [3:0] ch, input logic [3:0] dev,
                              input logic [6:0] lo, input logic [6:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LISTEN_CHANNEL;
        cfg_data  <= {3'd0, ch};
        @(posedge clk);
        cfg_index <= CFG_DEVICE_ID;
        cfg_data  <= {3'd0, dev};
        @(posedge clk);
        cfg_index <= CFG_LOWEST_NOTE;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_HIGHEST_NOTE;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        chan_now = ch;
        dev_now  = dev;
        lo_now   = lo;
        hi_now   = hi;
        settings_used++;
    endtask

    function automatic logic [7:0] data_pick();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return {1'b0, 7'($urandom)};
        endcase
    endfunction

    // Notes cluster around the edges of the configured range.
    function automatic logic [7:0] note_pick();
        logic [6:0] n;
        case ($urandom_range(0, 5))
            0:       n = lo_now;
            1:       n = hi_now;
            2:       n = lo_now - 7'd1;
            3:       n = hi_now + 7'd1;
            default: n = 7'($urandom);
        endcase
        return {1'b0, n};
    endfunction

    function automatic logic [7:0] realtime_pick();
        case ($urandom_range(0, 3))
            0:       return MIDI_SYNC_CLOCK;
            1:       return MIDI_START;
            2:       return MIDI_RESUME;
            default: return 8'($urandom_range(MIDI_REALTIME, MIDI_RT_LAST));
        endcase
    endfunction

    // Queue one byte of a message; a broken message stops after cut_left
    // bytes, and real-time bytes or ticks now and then land in between.
    task automatic msg_byte(input logic [7:0] b);
        if (cut_left == 0)
            return;
        cut_left--;
        if ($urandom_range(0, 24) == 0)
            beat_q.push_back('{OP_BYTE, realtime_pick()});
        if ($urandom_range(0, 24) == 0)
            beat_q.push_back('{OP_TICK, 8'($urandom)});
        beat_q.push_back('{OP_BYTE, b});
    endtask

    // One random message, mostly well formed and mostly on our channel.
    task automatic make_traffic();
        int pick;
        int reps;
        logic [3:0] ch;
        pick     = $urandom_range(0, 99);
        reps     = $urandom_range(1, 3);
        ch       = ($urandom_range(0, 7) == 0) ? 4'($urandom) : chan_now;
        cut_left = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4) : 64;
        if (pick < 20) begin
            msg_byte({STAT_NOTE_ON, ch});
            repeat (reps) begin
                msg_byte(note_pick());
                msg_byte(($urandom_range(0, 3) == 0) ? 8'h00 : data_pick());
            end
        end else if (pick < 30) begin
            msg_byte({STAT_NOTE_OFF, ch});
            repeat (reps) begin
                msg_byte(note_pick());
                msg_byte(data_pick());
            end
        end else if (pick < 45) begin
            msg_byte({STAT_CTRL, ch});
            repeat (reps) begin
                msg_byte(($urandom_range(0, 1) == 0) ? {1'b0, MOD_WHEEL_CC} : data_pick());
                msg_byte(data_pick());
            end
        end else if (pick < 55) begin
            msg_byte({STAT_PITCH_BEND, ch});
            repeat (reps) begin
                msg_byte(data_pick());
                msg_byte(data_pick());
            end
        end else if (pick < 63) begin
            msg_byte({STAT_PRESSURE, ch});
            repeat (reps) msg_byte(data_pick());
        end else if (pick < 68) begin
            msg_byte({STAT_PROGRAM, ch});
            repeat (reps) msg_byte(data_pick());
        end else if (pick < 80) begin
            msg_byte(MIDI_SYSEX_START);
            msg_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : {1'b0, SYSEX_MAKER_ID});
            msg_byte(($urandom_range(0, 6) == 0) ? 8'($urandom) : {dev_now, chan_now});
            repeat (4) msg_byte(data_pick());
            msg_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : MIDI_SYSEX_END);
        end else if (pick < 88) begin
            beat_q.push_back('{OP_BYTE, realtime_pick()});
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 20)) beat_q.push_back('{OP_TICK, 8'($urandom)});
        end else begin
            beat_q.push_back('{OP_BYTE, 8'($urandom)});
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [7:0] dir_seq[];
        int         phase_start;
        bit         pressed;

        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_LISTEN_CHANNEL;
        cfg_data   = '0;
        item_valid = 1'b0;
        opcode     = OP_BYTE;
        rx_byte    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every message kind, real-time bytes in and out of
        // messages, foreign channel, aborted and mismatched SysEx.
        set_config(4'd5, 4'd10, 7'd20, 7'd100);
        dir_seq = '{
            MIDI_SYNC_CLOCK, MIDI_START, MIDI_RESUME, MIDI_RT_LAST, MIDI_SONG_SELECT,
            {STAT_NOTE_ON, chan_now + 4'd1}, 8'h3C,
            // Maker byte that is a status: SysEx is dropped and the byte
            // opens a note-on; a clock byte lands between key and velocity.
            MIDI_SYSEX_START, {STAT_NOTE_ON, chan_now}, {1'b0, lo_now}, MIDI_SYNC_CLOCK,
            8'h7F,
            {1'b0, hi_now}, 8'h00, {1'b0, hi_now + 7'd1}, 8'h40,
            // A status byte under running note-on status ends it.
            {STAT_CTRL, chan_now}, {1'b0, MOD_WHEEL_CC}, 8'h7F,
            {STAT_PITCH_BEND, chan_now}, 8'h00, 8'h7F,
            {STAT_PRESSURE, chan_now}, 8'h7F,
            {STAT_PROGRAM, chan_now}, 8'h33,
            {STAT_NOTE_OFF, chan_now}, 8'h40, 8'h00,
            MIDI_SYSEX_START, {1'b0, SYSEX_MAKER_ID}, 8'h00,
            MIDI_SYSEX_START, {1'b0, SYSEX_MAKER_ID}, {dev_now, chan_now},
            8'h7F, 8'h7F, 8'h7F, 8'h7F, MIDI_SYSEX_END
        };
        send_beat(OP_TICK, 8'hFF);
        foreach (dir_seq[i])
            send_beat(OP_BYTE, dir_seq[i]);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: set_config(4'd0, 4'd0, 7'd0, 7'd127);
                1: set_config(4'd15, 4'd15, 7'd127, 7'd127);
                2: set_config(4'd7, 4'd3, 7'd90, 7'd30);
                3: set_config(4'($urandom), 4'($urandom), 7'($urandom_range(0, 60)),
                              7'($urandom_range(61, 127)));
                4: set_config(4'($urandom), 4'($urandom), 7'd0, 7'd0);
                default: set_config(4'd9, 4'd6, 7'd36, 7'd96);
            endcase
            // The last phase runs with no idling on either side.
            idling_on   <= (ph != 5);
            phase_start = beats_sent;
            pressed     = 1'b0;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                make_traffic();
                if ((ph == 1 || ph == 3) && !pressed && beats_sent - phase_start > 100) begin
                    holds_asked <= holds_asked + 1;
                    pressed     = 1'b1;
                end
                flush_beats();
            end
        end

        drain();
        $display("Covered %0d beats (%0d timer ticks) under %0d register settings,",
                 beats_sent, ticks_sent, settings_used);
        $display("with %0d events compared in order and %0d long consumer hold-offs.",
                 events_checked, holds_done);
        if (mismatch_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
